>>> rtl/mne_pkg.sv
`default_nettype none

package mne_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);

    // echo source codes
    localparam logic [1:0] ES_DIN1 = 2'd0;
    localparam logic [1:0] ES_DIN2 = 2'd1;
    localparam logic [1:0] ES_OFF  = 2'd2;
    localparam logic [1:0] ES_BOTH = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_ECHO_SOURCE    = 2'd0;
    localparam logic [1:0] CFG_REPEAT_COUNT   = 2'd1;
    localparam logic [1:0] CFG_TICK_DIVIDER   = 2'd2;
    localparam logic [1:0] CFG_VELOCITY_DECAY = 2'd3;

    // midi constants
    localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
    localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
    localparam logic [3:0] NIB_CTRL     = 4'hB;
    localparam logic [7:0] CC_ALL_OFF   = 8'h7B;
    localparam int         NUM_CHAN     = 16;

    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_TICK    = 2'd1,
        OP_PANIC   = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_UPD,
        S_EMIT,
        S_END,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic [7:0]  status;
        logic [7:0]  note;
        logic [7:0]  orig;
        logic [7:0]  velocity;
        logic [15:0] countdown;
        logic [7:0]  repeats;
    } t_entry;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] i);
        return (i == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

endpackage

`default_nettype wire

>>> rtl/mne_entry_alu.sv
`default_nettype none

module mne_entry_alu (
    input  mne_pkg::t_entry i_entry,
    input  logic [15:0]     i_divider,
    input  logic [7:0]      i_decay,
    output mne_pkg::t_entry o_entry,
    output logic            o_fire,
    output logic [7:0]      o_velocity
);
    import mne_pkg::*;

    logic        is_on;
    logic [15:0] cd_dec;
    logic [7:0]  rep_dec;

    assign is_on      = (i_entry.status[7:4] == NIB_NOTE_ON);
    assign cd_dec     = (i_entry.countdown != 16'd0) ? i_entry.countdown - 16'd1 : 16'd0;
    assign rep_dec    = i_entry.repeats - 8'd1;
    assign o_fire     = (i_entry.repeats != 8'd0) && (cd_dec == 16'd0);
    // the word sent carries the velocity from before this repeat's decay
    assign o_velocity = is_on ? i_entry.velocity : i_entry.orig;

    always_comb begin
        o_entry = i_entry;
        if (i_entry.repeats != 8'd0) begin
            o_entry.countdown = cd_dec;
            if (cd_dec == 16'd0) begin
                o_entry.repeats = rep_dec;
                if (rep_dec != 8'd0) begin
                    o_entry.countdown = i_divider;
                    if (is_on && i_entry.velocity != 8'd0) begin
                        o_entry.velocity = (i_entry.velocity > i_decay)
                                           ? i_entry.velocity - i_decay : 8'd1;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/midi_note_echo_engine.sv
`default_nettype none

// MIDI echo engine. Captured messages sit in a 32-slot circular queue (31 usable)
// held in a simple dual-port memory. An enqueue or an unknown operation never
// leaves the idle state. A tick walks the queue from head to tail one entry at a
// time through a shared entry update unit: for each entry a memory read, then
// update and write-back, then the words it sends; the walk closes with a head
// update and a flush of the held-back word. A panic sends one word per cycle
// unless stalled, 16 or 32 in all. Each result word is held back in a pending
// register so that the last word of an item can carry o_last_of_run; output
// back-pressure stalls the sequencer. The block takes a new item only while its
// sequencer is idle, even if a finished word still waits at the output.

module midi_note_echo_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_status_byte,
    input  logic [7:0]  i_first_data,
    input  logic [7:0]  i_second_data,
    input  logic        i_source_port,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_out_port,
    output logic [7:0]  o_out_status,
    output logic [7:0]  o_out_data1,
    output logic [7:0]  o_out_data2,
    output logic        o_last_of_run,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import mne_pkg::*;

    t_state r_state, n_state;

    logic [1:0]  r_src, n_src;
    logic [7:0]  r_rep, n_rep;
    logic [15:0] r_div, n_div;
    logic [7:0]  r_decay, n_decay;

    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [PTR_W-1:0] r_idx, n_idx;
    logic [PTR_W-1:0] r_nhead, n_nhead;
    logic             r_prefix, n_prefix;
    logic             r_port, n_port;
    logic             r_panic, n_panic;
    logic [3:0]       r_ch, n_ch;
    logic [7:0]       r_msg_status, n_msg_status;
    logic [7:0]       r_msg_d1, n_msg_d1;
    logic [7:0]       r_msg_d2, n_msg_d2;

    logic       r_pv, n_pv;
    logic       r_pend_port, n_pend_port;
    logic [7:0] r_pend_status, n_pend_status;
    logic [7:0] r_pend_d1, n_pend_d1;
    logic [7:0] r_pend_d2, n_pend_d2;

    logic       r_ov, n_ov;
    logic       r_out_port, n_out_port;
    logic [7:0] r_out_status, n_out_status;
    logic [7:0] r_out_d1, n_out_d1;
    logic [7:0] r_out_d2, n_out_d2;
    logic       r_last, n_last;

    t_entry           mem [QUEUE_DEPTH];
    t_entry           r_rdata;
    logic             mem_we;
    logic [PTR_W-1:0] mem_waddr;
    t_entry           mem_wdata;

    t_entry     alu_entry;
    logic       alu_fire;
    logic [7:0] alu_vel;

    logic       accept;
    logic       out_free;
    logic       can_emit;
    logic       walk_last;
    logic       start_port;
    logic       more_port;
    logic       enq_active;
    logic       q_full;
    logic [7:0] enq_status;
    logic [1:0] cfg_src;
    logic [7:0] cfg_rep;

    mne_entry_alu u_alu (
        .i_entry    (r_rdata),
        .i_divider  (r_div),
        .i_decay    (r_decay),
        .o_entry    (alu_entry),
        .o_fire     (alu_fire),
        .o_velocity (alu_vel)
    );

    assign o_in_ready    = (r_state == S_IDLE);
    assign accept        = i_in_valid && o_in_ready;
    assign out_free      = !r_ov || i_out_ready;
    assign can_emit      = !r_pv || out_free;
    assign walk_last     = (next_slot(r_idx) == r_tail);
    assign start_port    = (r_src == ES_DIN2);
    assign more_port     = !r_port && (r_src == ES_BOTH);
    assign q_full        = (next_slot(r_tail) == r_head);
    assign enq_active    = (r_src != ES_OFF) && (r_rep != 8'd0) &&
                           ((r_src == ES_BOTH) || (r_src == {1'b0, i_source_port}));
    assign enq_status    = ((i_status_byte[7:4] == NIB_NOTE_ON) && (i_second_data == 8'd0))
                           ? {NIB_NOTE_OFF, i_status_byte[3:0]} : i_status_byte;

    assign o_out_valid   = r_ov;
    assign o_out_port    = r_out_port;
    assign o_out_status  = r_out_status;
    assign o_out_data1   = r_out_d1;
    assign o_out_data2   = r_out_d2;
    assign o_last_of_run = r_last;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_operation)
                        OP_TICK:  if (r_head != r_tail) n_state = S_RD;
                        OP_PANIC: if (r_src != ES_OFF) n_state = S_EMIT;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_RD: n_state = S_UPD;
            S_UPD: begin
                if (alu_fire)       n_state = S_EMIT;
                else if (walk_last) n_state = S_END;
                else                n_state = S_RD;
            end
            S_EMIT: begin
                if (can_emit && !more_port) begin
                    if (r_panic) begin
                        if (r_ch == 4'(NUM_CHAN - 1)) n_state = S_FLUSH;
                    end else if (walk_last) begin
                        n_state = S_END;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_END:   n_state = S_FLUSH;
            S_FLUSH: if (!r_pv || out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_src         = r_src;
        n_rep         = r_rep;
        n_div         = r_div;
        n_decay       = r_decay;
        n_head        = r_head;
        n_tail        = r_tail;
        n_idx         = r_idx;
        n_nhead       = r_nhead;
        n_prefix      = r_prefix;
        n_port        = r_port;
        n_panic       = r_panic;
        n_ch          = r_ch;
        n_msg_status  = r_msg_status;
        n_msg_d1      = r_msg_d1;
        n_msg_d2      = r_msg_d2;
        n_pv          = r_pv;
        n_pend_port   = r_pend_port;
        n_pend_status = r_pend_status;
        n_pend_d1     = r_pend_d1;
        n_pend_d2     = r_pend_d2;
        n_ov          = (r_ov && i_out_ready) ? 1'b0 : r_ov;
        n_out_port    = r_out_port;
        n_out_status  = r_out_status;
        n_out_d1      = r_out_d1;
        n_out_d2      = r_out_d2;
        n_last        = r_last;
        mem_we        = 1'b0;
        mem_waddr     = r_idx;
        mem_wdata     = alu_entry;
        cfg_src       = r_src;
        cfg_rep       = r_rep;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_operation)
                        OP_ENQUEUE: begin
                            if (enq_active && !q_full) begin
                                mem_we              = 1'b1;
                                mem_waddr           = r_tail;
                                mem_wdata.status    = enq_status;
                                mem_wdata.note      = i_first_data;
                                mem_wdata.orig      = i_second_data;
                                mem_wdata.velocity  = i_second_data;
                                mem_wdata.countdown = r_div;
                                mem_wdata.repeats   = r_rep;
                                n_tail              = next_slot(r_tail);
                            end
                        end
                        OP_TICK: begin
                            n_idx    = r_head;
                            n_nhead  = r_head;
                            n_prefix = 1'b1;
                            n_panic  = 1'b0;
                        end
                        OP_PANIC: begin
                            n_head  = '0;
                            n_tail  = '0;
                            n_panic = 1'b1;
                            n_ch    = 4'd0;
                            n_port  = start_port;
                        end
                        default: ;
                    endcase
                end
            end
            S_UPD: begin
                mem_we       = 1'b1;
                mem_waddr    = r_idx;
                mem_wdata    = alu_entry;
                n_msg_status = r_rdata.status;
                n_msg_d1     = r_rdata.note;
                n_msg_d2     = alu_vel;
                n_port       = start_port;
                // finished entries in an unbroken run from the head get dropped
                if (r_prefix && alu_entry.repeats == 8'd0) n_nhead = next_slot(r_idx);
                else                                       n_prefix = 1'b0;
                if (!alu_fire && !walk_last) n_idx = next_slot(r_idx);
            end
            S_EMIT: begin
                if (can_emit) begin
                    if (r_pv) begin
                        n_ov         = 1'b1;
                        n_out_port   = r_pend_port;
                        n_out_status = r_pend_status;
                        n_out_d1     = r_pend_d1;
                        n_out_d2     = r_pend_d2;
                        n_last       = 1'b0;
                    end
                    n_pv        = 1'b1;
                    n_pend_port = r_port;
                    if (r_panic) begin
                        n_pend_status = {NIB_CTRL, r_ch};
                        n_pend_d1     = CC_ALL_OFF;
                        n_pend_d2     = 8'd0;
                    end else begin
                        n_pend_status = r_msg_status;
                        n_pend_d1     = r_msg_d1;
                        n_pend_d2     = r_msg_d2;
                    end
                    if (more_port) begin
                        n_port = 1'b1;
                    end else begin
                        n_port = start_port;
                        if (r_panic)         n_ch  = r_ch + 4'd1;
                        else if (!walk_last) n_idx = next_slot(r_idx);
                    end
                end
            end
            S_END: n_head = r_nhead;
            S_FLUSH: begin
                if (r_pv && out_free) begin
                    n_ov         = 1'b1;
                    n_out_port   = r_pend_port;
                    n_out_status = r_pend_status;
                    n_out_d1     = r_pend_d1;
                    n_out_d2     = r_pend_d2;
                    n_last       = 1'b1;
                    n_pv         = 1'b0;
                end
            end
            default: ;
        endcase

        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ECHO_SOURCE:    cfg_src = i_cfg_data[1:0];
                CFG_REPEAT_COUNT:   cfg_rep = i_cfg_data[7:0];
                CFG_TICK_DIVIDER:   n_div   = i_cfg_data;
                CFG_VELOCITY_DECAY: n_decay = i_cfg_data[7:0];
                default: ;
            endcase
            n_src = cfg_src;
            n_rep = cfg_rep;
            if (cfg_src == ES_OFF || cfg_rep == 8'd0) begin
                n_head = '0;
                n_tail = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_src   <= ES_OFF;
            r_rep   <= 8'd0;
            r_div   <= 16'd0;
            r_decay <= 8'd0;
            r_head  <= '0;
            r_tail  <= '0;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_src   <= n_src;
            r_rep   <= n_rep;
            r_div   <= n_div;
            r_decay <= n_decay;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_pv    <= n_pv;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx         <= n_idx;
        r_nhead       <= n_nhead;
        r_prefix      <= n_prefix;
        r_port        <= n_port;
        r_panic       <= n_panic;
        r_ch          <= n_ch;
        r_msg_status  <= n_msg_status;
        r_msg_d1      <= n_msg_d1;
        r_msg_d2      <= n_msg_d2;
        r_pend_port   <= n_pend_port;
        r_pend_status <= n_pend_status;
        r_pend_d1     <= n_pend_d1;
        r_pend_d2     <= n_pend_d2;
        r_out_port    <= n_out_port;
        r_out_status  <= n_out_status;
        r_out_d1      <= n_out_d1;
        r_out_d2      <= n_out_d2;
        r_last        <= n_last;
    end

    // no held-back word may survive into idle, or it would be lost
    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pv)
        else $error("pending word left behind at end of item");

    // the walk never steps onto the tail slot
    a_walk_in_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD || r_state == S_UPD) |-> (r_idx != r_tail))
        else $error("queue walk past tail");

    // second port only used when echoing to both or to din2 alone
    a_port_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_port) |-> (r_src == ES_DIN2 || r_src == ES_BOTH))
        else $error("word routed to din2 without echo there");

    // a read is always followed by its update step
    a_read_then_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |=> (r_state == S_UPD))
        else $error("memory read not followed by update");

endmodule

`default_nettype wire

>>> tb/sv/midi_note_echo_checker.sv
`timescale 1ns / 100ps

module midi_note_echo_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_status_byte,
    input  logic [7:0]  i_first_data,
    input  logic [7:0]  i_second_data,
    input  logic        i_source_port,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_out_port,
    input  logic [7:0]  i_out_status,
    input  logic [7:0]  i_out_data1,
    input  logic [7:0]  i_out_data2,
    input  logic        i_last_of_run,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);
    import mne_pkg::*;

    typedef struct packed {
        logic       port;
        logic [7:0] status;
        logic [7:0] data1;
        logic [7:0] data2;
        logic       last;
    } t_echo_word;

    // shadow of the configuration
    logic [1:0]  echo_src;
    logic [7:0]  echo_reps;
    logic [15:0] tick_div;
    logic [7:0]  vel_decay;

    // shadow of the echo queue
    logic [7:0]       q_status [QUEUE_DEPTH];
    logic [7:0]       q_note   [QUEUE_DEPTH];
    logic [7:0]       q_orig   [QUEUE_DEPTH];
    logic [7:0]       q_vel    [QUEUE_DEPTH];
    logic [15:0]      q_count  [QUEUE_DEPTH];
    logic [7:0]       q_left   [QUEUE_DEPTH];
    logic [PTR_W-1:0] q_head;
    logic [PTR_W-1:0] q_tail;

    t_echo_word due_words[$];
    t_echo_word item_words[$];
    int         words_seen;

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    function automatic logic [PTR_W-1:0] next_idx(input logic [PTR_W-1:0] i);
        return (int'(i) + 1 >= QUEUE_DEPTH) ? '0 : i + 1'b1;
    endfunction

    function automatic void clear_model();
        echo_src  = ES_OFF;
        echo_reps = '0;
        tick_div  = '0;
        vel_decay = '0;
        q_head    = '0;
        q_tail    = '0;
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            q_status[k] = '0;
            q_note[k]   = '0;
            q_orig[k]   = '0;
            q_vel[k]    = '0;
            q_count[k]  = '0;
            q_left[k]   = '0;
        end
    endfunction

    function automatic void apply_cfg(input logic [1:0] idx, input logic [15:0] data);
        case (idx)
            CFG_ECHO_SOURCE:    echo_src  = data[1:0];
            CFG_REPEAT_COUNT:   echo_reps = data[7:0];
            CFG_TICK_DIVIDER:   tick_div  = data;
            CFG_VELOCITY_DECAY: vel_decay = data[7:0];
            default: ;
        endcase
        if (echo_src == ES_OFF || echo_reps == 0) begin
            q_head = '0;
            q_tail = '0;
        end
    endfunction

    // one message out on every port that echo is routed to
    function automatic void play(input logic [7:0] st, input logic [7:0] d1,
                                 input logic [7:0] d2);
        if (echo_src == ES_DIN1 || echo_src == ES_BOTH)
            item_words.push_back('{1'b0, st, d1, d2, 1'b0});
        if (echo_src == ES_DIN2 || echo_src == ES_BOTH)
            item_words.push_back('{1'b1, st, d1, d2, 1'b0});
    endfunction

    function automatic void predict_item(input logic [1:0] op, input logic [7:0] st,
                                         input logic [7:0] d1, input logic [7:0] d2,
                                         input logic src);
        logic [PTR_W-1:0] idx;
        logic [7:0]       st_kept;
        logic             hit;
        logic             note_on;
        item_words.delete();
        case (op)
            OP_ENQUEUE: begin
                hit = (echo_src == ES_BOTH) || (echo_src == {1'b0, src});
                if (echo_src != ES_OFF && hit && echo_reps != 0
                        && next_idx(q_tail) != q_head) begin
                    st_kept = st;
                    // note-on at zero velocity is kept as a note-off
                    if (st[7:4] == NIB_NOTE_ON && d2 == 0)
                        st_kept = {NIB_NOTE_OFF, st[3:0]};
                    q_status[q_tail] = st_kept;
                    q_note[q_tail]   = d1;
                    q_orig[q_tail]   = d2;
                    q_vel[q_tail]    = d2;
                    q_count[q_tail]  = tick_div;
                    q_left[q_tail]   = echo_reps;
                    q_tail = next_idx(q_tail);
                end
            end
            OP_TICK: begin
                if (q_head != q_tail) begin
                    idx = q_head;
                    do begin
                        if (q_left[idx] != 0) begin
                            if (q_count[idx] != 0)
                                q_count[idx] = q_count[idx] - 1'b1;
                            if (q_count[idx] == 0) begin
                                note_on = (q_status[idx][7:4] == NIB_NOTE_ON);
                                play(q_status[idx], q_note[idx],
                                     note_on ? q_vel[idx] : q_orig[idx]);
                                q_left[idx] = q_left[idx] - 1'b1;
                                if (q_left[idx] != 0) begin
                                    q_count[idx] = tick_div;
                                    if (note_on && q_vel[idx] != 0)
                                        q_vel[idx] = (q_vel[idx] > vel_decay)
                                                     ? q_vel[idx] - vel_decay : 8'd1;
                                end
                            end
                        end
                        idx = next_idx(idx);
                    end while (idx != q_tail);
                    // only finished entries at the head are dropped
                    while (q_head != q_tail && q_left[q_head] == 0)
                        q_head = next_idx(q_head);
                end
            end
            OP_PANIC: begin
                for (int ch = 0; ch < NUM_CHAN; ch++)
                    play({NIB_CTRL, 4'(ch)}, CC_ALL_OFF, 8'h00);
                q_head = '0;
                q_tail = '0;
            end
            default: ;
        endcase
        if (item_words.size() > 0)
            item_words[item_words.size() - 1].last = 1'b1;
        foreach (item_words[k])
            due_words.push_back(item_words[k]);
    endfunction

    task automatic report(input string what);
        if (o_errors < 100)
            $display("%0t ns: word %0d: %s", $time, words_seen, what);
        o_errors = o_errors + 1;
    endtask

    task automatic check_word();
        t_echo_word want;
        if (due_words.size() == 0) begin
            report($sformatf("unexpected word port %0d status %02h %02h %02h",
                             i_out_port, i_out_status, i_out_data1, i_out_data2));
        end else begin
            want = due_words.pop_front();
            if (i_out_port !== want.port)
                report($sformatf("port %0d, want %0d", i_out_port, want.port));
            if (i_out_status !== want.status)
                report($sformatf("status %02h, want %02h", i_out_status, want.status));
            if (i_out_data1 !== want.data1)
                report($sformatf("data1 %02h, want %02h", i_out_data1, want.data1));
            if (i_out_data2 !== want.data2)
                report($sformatf("data2 %02h, want %02h", i_out_data2, want.data2));
            if (i_last_of_run !== want.last)
                report($sformatf("last %0d, want %0d", i_last_of_run, want.last));
        end
        words_seen++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_model();
            due_words.delete();
            words_seen = 0;
        end else begin
            if (i_cfg_we)
                apply_cfg(i_cfg_index, i_cfg_data);
            if (i_in_valid && i_in_ready)
                predict_item(i_operation, i_status_byte, i_first_data, i_second_data,
                             i_source_port);
            if (i_out_valid && i_out_ready)
                check_word();
        end
        o_pending = due_words.size();
    end

endmodule

>>> tb/sv/tb_midi_note_echo_engine.sv
`timescale 1ns / 100ps

module tb_midi_note_echo_engine;
    import mne_pkg::*;

    localparam logic [1:0] OP_NONE      = 2'd3;
    localparam int         SETTLE_WAIT  = 160;
    localparam int         LONG_STALL   = 600;
    localparam int         CYCLE_LIMIT  = 1000000;
    localparam int         RAND_PHASES  = 8;
    localparam int         PHASE_ITEMS  = 27;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  operation = OP_TICK;
    logic [7:0]  status_byte = '0;
    logic [7:0]  first_data = '0;
    logic [7:0]  second_data = '0;
    logic        source_port = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        out_port;
    logic [7:0]  out_status;
    logic [7:0]  out_data1;
    logic [7:0]  out_data2;
    logic        last_of_run;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    int mismatches;
    int pending;
    int cycle_count = 0;
    int idle_max = 8;
    bit stall_req = 1'b0;

    always #5 clk = ~clk;

    midi_note_echo_engine dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_operation  (operation),
        .i_status_byte(status_byte),
        .i_first_data (first_data),
        .i_second_data(second_data),
        .i_source_port(source_port),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_out_port   (out_port),
        .o_out_status (out_status),
        .o_out_data1  (out_data1),
        .o_out_data2  (out_data2),
        .o_last_of_run(last_of_run),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    midi_note_echo_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_operation  (operation),
        .i_status_byte(status_byte),
        .i_first_data (first_data),
        .i_second_data(second_data),
        .i_source_port(source_port),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_port   (out_port),
        .i_out_status (out_status),
        .i_out_data1  (out_data1),
        .i_out_data2  (out_data2),
        .i_last_of_run(last_of_run),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_errors     (mismatches),
        .o_pending    (pending)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[midi_note_echo_engine] ERROR");
            $finish;
        end
    end

    // output side: random back-pressure, plus one long hold-off on request
    initial begin : sink
        int gap;
        forever begin
            if (stall_req) begin
                stall_req = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_STALL) @(posedge clk);
            end
            gap = $urandom_range(0, idle_max);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    task automatic send(input logic [1:0] op, input logic [7:0] st, input logic [7:0] d1,
                        input logic [7:0] d2, input logic src);
        int gap;
        gap = $urandom_range(0, idle_max);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        status_byte <= st;
        first_data  <= d1;
        second_data <= d2;
        source_port <= src;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // stop offering and wait for every expected word
    task automatic drain();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
    endtask

    // drain, then give a silent walk time to finish
    task automatic settle();
        drain();
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic setup(input logic [1:0] src, input logic [7:0] reps,
                         input logic [15:0] div, input logic [7:0] decay);
        settle();
        write_reg(CFG_TICK_DIVIDER, div);
        write_reg(CFG_VELOCITY_DECAY, 16'(decay));
        write_reg(CFG_REPEAT_COUNT, 16'(reps));
        write_reg(CFG_ECHO_SOURCE, 16'(src));
    endtask

    function automatic logic [7:0] rand_status();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 12)
            return {NIB_NOTE_ON, 4'($urandom)};
        if (pick < 15)
            return {NIB_NOTE_OFF, 4'($urandom)};
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] rand_velocity();
        return ($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom);
    endfunction

    task automatic random_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            send(OP_ENQUEUE, rand_status(), 8'($urandom), rand_velocity(),
                 1'($urandom));
        else if (pick < 90)
            send(OP_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
        else if (pick < 95)
            send(OP_PANIC, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
        else
            send(OP_NONE, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
    endtask

    task automatic random_setup();
        int          pick;
        logic [1:0]  src;
        logic [7:0]  reps;
        logic [15:0] div;
        logic [7:0]  decay;
        pick = $urandom_range(0, 7);
        src  = (pick < 2) ? ES_DIN1 : (pick < 4) ? ES_DIN2 : (pick < 7) ? ES_BOTH : ES_OFF;
        pick = $urandom_range(0, 7);
        reps = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom_range(1, 6));
        pick = $urandom_range(0, 7);
        div  = (pick == 0) ? 16'hFFFF : (pick == 1) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 3));
        pick = $urandom_range(0, 3);
        decay = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom);
        setup(src, reps, div, decay);
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // both ports, three repeats every tick, heavy decay
        setup(ES_BOTH, 8'd3, 16'd0, 8'h30);
        send(OP_ENQUEUE, 8'h90, 8'h00, 8'h7F, 1'b0);
        send(OP_ENQUEUE, 8'h93, 8'h7F, 8'h00, 1'b1);
        send(OP_ENQUEUE, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send(OP_ENQUEUE, 8'h00, 8'h00, 8'h00, 1'b0);
        send(OP_ENQUEUE, 8'h9F, 8'h40, 8'h01, 1'b0);
        send(OP_NONE, 8'hAA, 8'h55, 8'hAA, 1'b1);
        repeat (4) send(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0);
        send(OP_PANIC, 8'h00, 8'h00, 8'h00, 1'b0);

        // din1 only, divider of two, decay to the floor
        setup(ES_DIN1, 8'd2, 16'd2, 8'hFF);
        send(OP_ENQUEUE, 8'h95, 8'h3C, 8'h64, 1'b1);
        send(OP_ENQUEUE, 8'h95, 8'h3C, 8'h64, 1'b0);
        repeat (4) send(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0);

        // a short-lived entry between two longer ones is skipped, not dropped
        setup(ES_DIN2, 8'd3, 16'd0, 8'd1);
        send(OP_ENQUEUE, 8'h91, 8'h10, 8'h40, 1'b1);
        settle();
        write_reg(CFG_REPEAT_COUNT, 16'd1);
        send(OP_ENQUEUE, 8'hC2, 8'h20, 8'h33, 1'b1);
        settle();
        write_reg(CFG_REPEAT_COUNT, 16'd3);
        send(OP_ENQUEUE, 8'h92, 8'h30, 8'h02, 1'b1);
        repeat (3) send(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0);

        // echo off: panic is silent, enqueue ignored
        setup(ES_OFF, 8'd0, 16'hFFFF, 8'd0);
        send(OP_PANIC, 8'h00, 8'h00, 8'h00, 1'b0);
        send(OP_ENQUEUE, 8'h90, 8'h01, 8'h01, 1'b0);

        // longest divider: ticks count down without sending
        setup(ES_BOTH, 8'd255, 16'hFFFF, 8'd255);
        send(OP_ENQUEUE, 8'h90, 8'h3C, 8'h7F, 1'b1);
        repeat (2) send(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0);

        // fill the queue past full, then walk it with the output held off
        setup(ES_BOTH, 8'd2, 16'd0, 8'd16);
        repeat (34)
            send(OP_ENQUEUE, rand_status(), 8'($urandom), rand_velocity(), 1'($urandom));
        stall_req = 1'b1;
        repeat (3) send(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0);

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            idle_max = (ph % 3 == 1) ? 0 : 8;
            if (ph == 2) begin
                setup(ES_BOTH, 8'd3, 16'd0, 8'($urandom));
                stall_req = 1'b1;
            end else begin
                random_setup();
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2)
                    drain();
                random_item();
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("[midi_note_echo_engine] OK");
        end else begin
            $display("[midi_note_echo_engine] ERROR");
        end
        $finish;
    end

endmodule

>>> midi_note_echo_engine.f
rtl/mne_pkg.sv
rtl/mne_entry_alu.sv
rtl/midi_note_echo_engine.sv
tb/sv/midi_note_echo_checker.sv
tb/sv/tb_midi_note_echo_engine.sv
